/* design/mcfb_pkg.sv */
// Shared types, constants and the byte-wise CRC-16 update for the frame builder.
package mcfb_pkg;

  localparam logic [7:0]  FrameStart   = 8'hFF;
  localparam logic [7:0]  FrameLength  = 8'h07;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'hA001;

  localparam int unsigned FrameBytes   = 9;
  localparam int unsigned IdxWidth     = $clog2(FrameBytes);
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QPtrWidth    = $clog2(QueueDepth);
  localparam int unsigned QCntWidth    = $clog2(QueueDepth + 1);

  localparam logic [IdxWidth-1:0] IdxStart  = IdxWidth'(0);
  localparam logic [IdxWidth-1:0] IdxLength = IdxWidth'(1);
  localparam logic [IdxWidth-1:0] IdxLeft   = IdxWidth'(2);
  localparam logic [IdxWidth-1:0] IdxPadL   = IdxWidth'(3);
  localparam logic [IdxWidth-1:0] IdxRight  = IdxWidth'(4);
  localparam logic [IdxWidth-1:0] IdxPadR   = IdxWidth'(5);
  localparam logic [IdxWidth-1:0] IdxFlags  = IdxWidth'(6);
  localparam logic [IdxWidth-1:0] IdxCrcLo  = IdxWidth'(7);
  localparam logic [IdxWidth-1:0] IdxCrcHi  = IdxWidth'(8);

  typedef struct packed {
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic [7:0] flags;
  } cmd_t;

  typedef struct packed {
    logic take;
  } q_ctrl_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

/* design/mcfb_front.sv */
// Front end: takes drive commands, forms the flags byte and holds them in a short queue.
module mcfb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          left_speed_i,
  input  logic [7:0]          right_speed_i,
  input  logic                left_forward_i,
  input  logic                right_forward_i,
  input  mcfb_pkg::q_ctrl_t   ctrl_i,
  output logic                cmd_valid_o,
  output mcfb_pkg::cmd_t      cmd_o
);

  mcfb_pkg::cmd_t                          entry_q [mcfb_pkg::QueueDepth];
  logic [mcfb_pkg::QPtrWidth-1:0]          wr_ptr_q, wr_ptr_d;
  logic [mcfb_pkg::QPtrWidth-1:0]          rd_ptr_q, rd_ptr_d;
  logic [mcfb_pkg::QCntWidth-1:0]          cnt_q, cnt_d;
  mcfb_pkg::cmd_t                          new_cmd;
  logic                                    wr_en;
  logic                                    rd_en;

  assign full        = (cnt_q == mcfb_pkg::QCntWidth'(mcfb_pkg::QueueDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = ctrl_i.take && cmd_valid_o;

  always_comb begin
    new_cmd.left_speed  = left_speed_i;
    new_cmd.right_speed = right_speed_i;
    new_cmd.flags       = {1'b0, left_forward_i, 1'b0, right_forward_i, 4'b0000};
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= new_cmd;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mcfb_pkg::QCntWidth'(mcfb_pkg::QueueDepth))
    else $error("Command queue count exceeds its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !rd_en) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("Command queue count did not grow on a lone write.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |=> $stable(cnt_q))
    else $error("Command queue count moved on a simultaneous read and write.");

endmodule

/* design/mcfb_back.sv */
// Back end: serializes one command into the nine-byte frame and folds the CRC in byte by byte.
module mcfb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  mcfb_pkg::cmd_t      cmd_i,
  output mcfb_pkg::q_ctrl_t   ctrl_o,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          frame_byte_o,
  output logic                frame_last_o
);

  logic                              busy_q, busy_d;
  logic [mcfb_pkg::IdxWidth-1:0]     idx_q, idx_d;
  logic [15:0]                       crc_q, crc_d;
  mcfb_pkg::cmd_t                    cmd_q;
  logic                              out_fire;
  logic                              at_last;
  logic                              load;
  logic [7:0]                        cur_byte;

  assign at_last  = (idx_q == mcfb_pkg::IdxCrcHi);
  assign empty    = !busy_q;
  assign out_fire = pop && busy_q;
  assign load     = cmd_valid_i && (!busy_q || (out_fire && at_last));

  assign ctrl_o.take  = load;

  always_comb begin
    case (idx_q)
      mcfb_pkg::IdxStart:  cur_byte = mcfb_pkg::FrameStart;
      mcfb_pkg::IdxLength: cur_byte = mcfb_pkg::FrameLength;
      mcfb_pkg::IdxLeft:   cur_byte = cmd_q.left_speed;
      mcfb_pkg::IdxPadL:   cur_byte = 8'h00;
      mcfb_pkg::IdxRight:  cur_byte = cmd_q.right_speed;
      mcfb_pkg::IdxPadR:   cur_byte = 8'h00;
      mcfb_pkg::IdxFlags:  cur_byte = cmd_q.flags;
      mcfb_pkg::IdxCrcLo:  cur_byte = crc_q[7:0];
      mcfb_pkg::IdxCrcHi:  cur_byte = crc_q[15:8];
      default:             cur_byte = 8'h00;
    endcase
  end

  assign frame_byte_o = cur_byte;
  assign frame_last_o = at_last;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    crc_d  = crc_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = mcfb_pkg::IdxStart;
      crc_d  = mcfb_pkg::CrcInit;
    end else if (out_fire) begin
      if (at_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
      if (idx_q inside {[mcfb_pkg::IdxLength : mcfb_pkg::IdxFlags]}) begin
        crc_d = mcfb_pkg::crc16_byte(crc_q, cur_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= mcfb_pkg::IdxStart;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (load) begin
      cmd_q <= cmd_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= mcfb_pkg::IdxCrcHi))
    else $error("Frame byte index ran past the last byte.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !at_last) |=> (busy_q && idx_q == $past(idx_q) + 1'b1))
    else $error("Frame byte index did not advance after a transaction.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && at_last && !cmd_valid_i) |=> !busy_q)
    else $error("Frame stayed busy after its last byte with no command queued.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !pop) |=> ($stable(idx_q) && busy_q))
    else $error("Frame position moved while the output was stalled.");

endmodule

/* design/motor_command_frame_builder.sv */
// Top level of the motor command frame builder: command queue front end and frame serializer.
//
//   channel   direction  handshake       payload
//   command   in         push / full     left_speed_i, right_speed_i, left_forward_i,
//                                        right_forward_i
//   frame     out        empty / pop     frame_byte_o, frame_last_o
//
// Each command yields nine frame bytes, one per cycle while pop is held high.
// The serializer in the back end sets the byte rate; the CRC takes in each popped byte from length to flags.
// A two-entry command queue lets new commands be taken while a frame is still going out.
// Reset empties the queue and the serializer; a stalled pop holds the current byte.
module motor_command_frame_builder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] left_speed_i,
  input  logic [7:0] right_speed_i,
  input  logic       left_forward_i,
  input  logic       right_forward_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] frame_byte_o,
  output logic       frame_last_o
);

  mcfb_pkg::q_ctrl_t ctrl;
  mcfb_pkg::cmd_t    cmd;
  logic              cmd_valid;

  mcfb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .left_speed_i    (left_speed_i),
    .right_speed_i   (right_speed_i),
    .left_forward_i  (left_forward_i),
    .right_forward_i (right_forward_i),
    .ctrl_i          (ctrl),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd)
  );

  mcfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .ctrl_o       (ctrl),
    .empty        (empty),
    .pop          (pop),
    .frame_byte_o (frame_byte_o),
    .frame_last_o (frame_last_o)
  );

endmodule
